>>> rtl/ictf_pkg.sv
// Package: shared constants, types and helpers for the complementary tilt filter.
package ictf_pkg;

   localparam int CordicSteps   = 16;
   localparam int StateFracBits = 20;
   localparam int CsrIdxW       = 2;

   localparam logic [CsrIdxW-1:0] CSR_GYRO_OFFSET_X = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_GYRO_OFFSET_Y = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_ROLL_WEIGHT   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_PITCH_WEIGHT  = 2'd3;

   localparam logic [15:0] WeightReset = 16'd62915;
   localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
   localparam logic [19:0] RateK  = 20'd572224;
   localparam logic [25:0] DeltaK = 26'd37501260;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CORDIC,
      ST_STEP,
      ST_BLEND,
      ST_DONE
   } state_type;

   // atan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:  atan_q30 = 30'd843314857;
         5'd1:  atan_q30 = 30'd497837829;
         5'd2:  atan_q30 = 30'd263043837;
         5'd3:  atan_q30 = 30'd133525159;
         5'd4:  atan_q30 = 30'd67021687;
         5'd5:  atan_q30 = 30'd33543516;
         5'd6:  atan_q30 = 30'd16775851;
         5'd7:  atan_q30 = 30'd8388437;
         5'd8:  atan_q30 = 30'd4194283;
         5'd9:  atan_q30 = 30'd2097149;
         5'd10: atan_q30 = 30'd1048576;
         5'd11: atan_q30 = 30'd524288;
         5'd12: atan_q30 = 30'd262144;
         5'd13: atan_q30 = 30'd131072;
         5'd14: atan_q30 = 30'd65536;
         5'd15: atan_q30 = 30'd32768;
         5'd16: atan_q30 = 30'd16384;
         5'd17: atan_q30 = 30'd8192;
         5'd18: atan_q30 = 30'd4096;
         5'd19: atan_q30 = 30'd2048;
         5'd20: atan_q30 = 30'd1024;
         5'd21: atan_q30 = 30'd512;
         5'd22: atan_q30 = 30'd256;
         5'd23: atan_q30 = 30'd128;
         default: atan_q30 = 30'd0;
      endcase
   endfunction

endpackage

>>> rtl/ictf_isqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module ictf_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        done,
   output logic [16:0] root
);

   logic [33:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [31:0] src_ff, src_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;
   logic [33:0] shifted;

   always_comb begin
      shifted = {rem_ff[31:0], src_ff[31:30]};
      trial   = {15'd0, root_ff[16:0], 2'b01};
      rem_in  = rem_ff;
      root_in = root_ff;
      src_in  = src_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         root_in = '0;
         src_in  = radicand;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = {src_ff[29:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      src_ff  <= src_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd15);
   assign root = root_in;

endmodule

>>> rtl/ictf_cordic_lane.sv
// One CORDIC vectoring lane computing atan2(y, x) in Q30, one step per cycle.
module ictf_cordic_lane #(
   parameter int CORDIC_STEPS = ictf_pkg::CordicSteps
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [17:0] y_in,
   input  logic signed [17:0] x_in,
   output logic               done,
   output logic signed [34:0] angle
);

   localparam int CntW = $clog2(CORDIC_STEPS + 1);

   logic signed [34:0] x_ff, x_in_v, y_ff, y_in_v;
   logic signed [34:0] z_ff, z_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic signed [34:0] xs, ys, x0, y0;
   logic signed [34:0] at;

   always_comb begin
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = 35'(signed'({1'b0, ictf_pkg::atan_q30(5'(cnt_ff))}));
      x0 = 35'(x_in) <<< 14;
      y0 = 35'(y_in) <<< 14;
      x_in_v  = x_ff;
      y_in_v  = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         if (x_in < 0) begin
            z_in   = (y_in >= 0) ? 35'(ictf_pkg::PiQ30) : -35'(ictf_pkg::PiQ30);
            x_in_v = -x0;
            y_in_v = -y0;
         end else begin
            z_in   = '0;
            x_in_v = x0;
            y_in_v = y0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_v = x_ff + ys;
            y_in_v = y_ff - xs;
            z_in   = z_ff + at;
         end else if (y_ff < 0) begin
            x_in_v = x_ff - ys;
            y_in_v = y_ff + xs;
            z_in   = z_ff - at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(CORDIC_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in_v;
      y_ff <= y_in_v;
      z_ff <= z_in;
   end

   assign done  = busy_ff && (cnt_ff == CntW'(CORDIC_STEPS - 1));
   assign angle = z_in;

endmodule

>>> rtl/ictf_blend.sv
// Merge stage: gyro step, weighted blend, state update, output rounding and rate scaling.
module ictf_blend #(
   parameter int STATE_FRAC_BITS = ictf_pkg::StateFracBits
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [2:0]                     phase,
   input  logic signed [16:0]             corr,
   input  logic [7:0]                     ms,
   input  logic signed [34:0]             accel_q30,
   input  logic [15:0]                    weight,
   output logic signed [15:0]             angle_out,
   output logic signed [15:0]             rate_out
);

   localparam int SW = STATE_FRAC_BITS + 4;
   localparam int AccShift = 30 - STATE_FRAC_BITS;
   localparam int StepShift = 48 - STATE_FRAC_BITS;
   localparam int OutShift = STATE_FRAC_BITS - 13;

   // phase 0: cms = corr*ms ; 1: step = cms*DeltaK ; 2: prod1 ; 3: prod2 ; 4: sum, update
   logic signed [24:0] cms_ff;
   logic signed [51:0] stp_ff;
   logic signed [SW+1:0] stepr;
   logic signed [SW+1:0] accr;
   logic signed [SW+19:0] p1_ff, p2_ff;
   logic signed [SW+20:0] sum;
   logic signed [SW+4:0]  bl;
   logic signed [SW-1:0]  est_ff, est_in;
   logic signed [SW-1:0]  lim_hi, lim_lo;
   logic signed [36:0]    rate_prod;
   logic signed [16:0]    rate_r;
   logic signed [SW-OutShift+1:0] ang_r;
   logic signed [51:0]    step_full;

   always_comb begin
      step_full = (stp_ff + (52'sd1 <<< (StepShift - 1))) >>> StepShift;
      stepr = (SW+2)'(step_full);
      if (AccShift == 0) accr = (SW+2)'(accel_q30);
      else accr = (SW+2)'((accel_q30 + (35'sd1 <<< (AccShift - 1))) >>> AccShift);
      sum = (SW+21)'(p1_ff) + (SW+21)'(p2_ff) + (SW+21)'(33'sd32768);
      bl  = (SW+5)'(sum >>> 16);
      lim_hi = {1'b0, {(SW-1){1'b1}}};
      lim_lo = {1'b1, {(SW-1){1'b0}}};
      est_in = est_ff;
      if (phase == 3'd4) begin
         if (bl > (SW+5)'(lim_hi)) est_in = lim_hi;
         else if (bl < (SW+5)'(lim_lo)) est_in = lim_lo;
         else est_in = SW'(bl);
      end
      rate_prod = 37'(corr) * 37'(signed'({1'b0, ictf_pkg::RateK}));
      rate_r = 17'((rate_prod + 37'sd524288) >>> 20);
      if (rate_r > 17'sd32767) rate_out = 16'sh7fff;
      else if (rate_r < -17'sd32768) rate_out = 16'sh8000;
      else rate_out = 16'(rate_r);
      if (OutShift == 0) ang_r = (SW-OutShift+2)'(est_ff);
      else ang_r = (SW-OutShift+2)'(((SW+1)'(est_ff) + ((SW+1)'(1) <<< (OutShift - 1)))
                                    >>> OutShift);
      if (ang_r > (SW-OutShift+2)'(32767)) angle_out = 16'sh7fff;
      else if (ang_r < -(SW-OutShift+2)'(32768)) angle_out = 16'sh8000;
      else angle_out = 16'(ang_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
      end else begin
         est_ff <= est_in;
      end
      case (phase)
         3'd0: cms_ff <= 25'(corr) * 25'(signed'({1'b0, ms}));
         3'd1: stp_ff <= 52'(cms_ff) * 52'(signed'({1'b0, ictf_pkg::DeltaK}));
         3'd2: p1_ff <= (SW+20)'(((SW+20)'(est_ff) + (SW+20)'(stepr)) *
                                 (SW+20)'(signed'({1'b0, weight})));
         3'd3: p2_ff <= (SW+20)'((SW+20)'(accr) *
                                 (SW+20)'(signed'(18'd65536 - {2'b0, weight})));
         default: ;
      endcase
   end

endmodule

>>> rtl/imu_complementary_tilt_filter.sv
// Top level: complementary tilt filter with a single square root and two CORDIC lanes.
// One transaction runs the square root, then the CORDIC lanes (roll and pitch lanes run
// together after the root), then the blend phases and the result hand-off; the time per
// sample is set mostly by the serial root and the CORDIC iterations.
// A new request is taken once the previous response has been accepted.
module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS    = ictf_pkg::CordicSteps,
   parameter int STATE_FRAC_BITS = ictf_pkg::StateFracBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_accel_x,
   input  logic signed [15:0]           req_accel_y,
   input  logic signed [15:0]           req_accel_z,
   input  logic signed [15:0]           req_gyro_x,
   input  logic signed [15:0]           req_gyro_y,
   input  logic [7:0]                   req_elapsed_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_roll_angle,
   output logic signed [15:0]           rsp_pitch_angle,
   output logic signed [15:0]           rsp_roll_rate,
   output logic signed [15:0]           rsp_pitch_rate,
   input  logic                         csr_write_enable,
   input  logic [ictf_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0]                  csr_write_data
);

   ictf_pkg::state_type state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic [7:0]  ms_ff;
   logic signed [15:0] offx_ff, offy_ff;
   logic [15:0] wr_ff, wp_ff;
   logic signed [34:0] ar_ff, ap_ff, ar_w, ap_w;
   logic [16:0] root;
   logic sq_start, sq_done, cr_start, cr_done, cp_done;
   logic [31:0] radicand;
   logic signed [16:0] cx, cy;
   logic signed [15:0] ang_r, ang_p, rate_r, rate_p;
   logic signed [15:0] o_ar_ff, o_ap_ff, o_rr_ff, o_rp_ff;
   logic accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ictf_pkg::ST_IDLE);
   assign radicand  = 32'(32'(req_accel_y) * 32'(req_accel_y)) +
                      32'(32'(req_accel_z) * 32'(req_accel_z));
   assign cx = 17'(gx_ff) - 17'(offx_ff);
   assign cy = 17'(gy_ff) - 17'(offy_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      sq_start = 1'b0;
      cr_start = 1'b0;
      case (state_ff)
         ictf_pkg::ST_IDLE: if (accept) begin
            sq_start = 1'b1;
            state_in = ictf_pkg::ST_SQRT;
         end
         ictf_pkg::ST_SQRT: if (sq_done) begin
            cr_start = 1'b1;
            state_in = ictf_pkg::ST_CORDIC;
         end
         ictf_pkg::ST_CORDIC: if (cr_done) begin
            phase_in = 3'd0;
            state_in = ictf_pkg::ST_STEP;
         end
         ictf_pkg::ST_STEP: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) state_in = ictf_pkg::ST_BLEND;
         end
         ictf_pkg::ST_BLEND: begin
            phase_in = 3'd7;
            state_in = ictf_pkg::ST_DONE;
         end
         ictf_pkg::ST_DONE: if (rsp_ready) state_in = ictf_pkg::ST_IDLE;
         default: state_in = ictf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ictf_pkg::ST_IDLE;
         phase_ff <= 3'd7;
         offx_ff  <= '0;
         offy_ff  <= '0;
         wr_ff    <= ictf_pkg::WeightReset;
         wp_ff    <= ictf_pkg::WeightReset;
      end else begin
         state_ff <= state_in;
         phase_ff <= (state_in == ictf_pkg::ST_STEP) ? phase_in : 3'd7;
         if (csr_write_enable) begin
            case (csr_index)
               ictf_pkg::CSR_GYRO_OFFSET_X: offx_ff <= csr_write_data;
               ictf_pkg::CSR_GYRO_OFFSET_Y: offy_ff <= csr_write_data;
               ictf_pkg::CSR_ROLL_WEIGHT:   wr_ff   <= csr_write_data;
               ictf_pkg::CSR_PITCH_WEIGHT:  wp_ff   <= csr_write_data;
               default: ;
            endcase
         end
      end
      if (accept) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
         gy_ff <= req_gyro_y;
         ms_ff <= req_elapsed_ms;
      end
      if (cr_done) ar_ff <= ar_w;
      if (cp_done) ap_ff <= ap_w;
      if (state_ff == ictf_pkg::ST_BLEND) begin
         o_ar_ff <= ang_r;
         o_ap_ff <= ang_p;
         o_rr_ff <= rate_r;
         o_rp_ff <= rate_p;
      end
   end

   ictf_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(radicand),
      .done(sq_done), .root(root)
   );

   ictf_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll_lane (
      .clock(clock), .reset(reset), .start(cr_start),
      .y_in(18'(ay_ff)), .x_in(18'(az_ff)), .done(cr_done), .angle(ar_w)
   );

   ictf_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch_lane (
      .clock(clock), .reset(reset), .start(cr_start),
      .y_in(-18'(ax_ff)), .x_in(18'(signed'({1'b0, root}))), .done(cp_done), .angle(ap_w)
   );

   ictf_blend #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_roll_blend (
      .clock(clock), .reset(reset), .phase(phase_ff), .corr(cx), .ms(ms_ff),
      .accel_q30(ar_ff), .weight(wr_ff), .angle_out(ang_r), .rate_out(rate_r)
   );

   ictf_blend #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_pitch_blend (
      .clock(clock), .reset(reset), .phase(phase_ff), .corr(cy), .ms(ms_ff),
      .accel_q30(ap_ff), .weight(wp_ff), .angle_out(ang_p), .rate_out(rate_p)
   );

   assign rsp_valid       = (state_ff == ictf_pkg::ST_DONE);
   assign rsp_roll_angle  = o_ar_ff;
   assign rsp_pitch_angle = o_ap_ff;
   assign rsp_roll_rate   = o_rr_ff;
   assign rsp_pitch_rate  = o_rp_ff;

endmodule

>>> rtl/ictf_checker.sv
// Port-level checker for the tilt filter, bound to the top level.
module ictf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_roll_angle
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_angle))
      else $error("response dropped or changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("accept did not start processing");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_roll_angle(rsp_roll_angle)
);

>>> tb/imu_complementary_tilt_filter_checker.sv
// Checker for the complementary tilt filter: predicts each sample's result and compares.
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [15:0]           req_accel_x,
   input  logic signed [15:0]           req_accel_y,
   input  logic signed [15:0]           req_accel_z,
   input  logic signed [15:0]           req_gyro_x,
   input  logic signed [15:0]           req_gyro_y,
   input  logic [7:0]                   req_elapsed_ms,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [15:0]           rsp_roll_angle,
   input  logic signed [15:0]           rsp_pitch_angle,
   input  logic signed [15:0]           rsp_roll_rate,
   input  logic signed [15:0]           rsp_pitch_rate,
   input  logic                         csr_write_enable,
   input  logic [ictf_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0]                  csr_write_data,
   output int                           fail_count,
   output int                           pending_count
);

   localparam int FracBits = ictf_pkg::StateFracBits;

   typedef struct {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_rate;
   } tilt_result_type;

   localparam longint AtanTable [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128
   };

   tilt_result_type expected_results[$];
   logic signed [15:0] offset_x, offset_y;
   logic [15:0]        weight_roll, weight_pitch;
   longint             roll_est, pitch_est;

   function automatic longint round_half_up(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(ictf_pkg::PiQ30) : -longint'(ictf_pkg::PiQ30);
         x = -x;
         y = -y;
      end
      x = x * 16384;
      y = y * 16384;
      for (int i = 0; i < ictf_pkg::CordicSteps && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + AtanTable[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - AtanTable[i];
         end
      end
      return z;
   endfunction

   function automatic longint blend_estimate(longint est, longint stp, longint acc, longint w);
      longint lim;
      lim = longint'(8) << FracBits;
      return clamp(round_half_up((est + stp) * w + acc * (65536 - w), 16), -lim, lim - 1);
   endfunction

   function automatic logic signed [15:0] to_out16(longint v);
      return 16'(clamp(v, -32768, 32767));
   endfunction

   task automatic predict_sample();
      longint ax, ay, az, cx, cy, ms, mag, acc_roll, acc_pitch, step_r, step_p;
      tilt_result_type r;
      ax = req_accel_x;
      ay = req_accel_y;
      az = req_accel_z;
      ms = longint'(req_elapsed_ms);
      cx = longint'(req_gyro_x) - longint'(offset_x);
      cy = longint'(req_gyro_y) - longint'(offset_y);
      mag = int_sqrt(longint'(ay * ay + az * az));
      acc_roll = round_half_up(vector_angle(ay, az), 30 - FracBits);
      acc_pitch = round_half_up(vector_angle(-ax, mag), 30 - FracBits);
      step_r = round_half_up(cx * ms * longint'(ictf_pkg::DeltaK), 48 - FracBits);
      step_p = round_half_up(cy * ms * longint'(ictf_pkg::DeltaK), 48 - FracBits);
      roll_est = blend_estimate(roll_est, step_r, acc_roll, longint'(weight_roll));
      pitch_est = blend_estimate(pitch_est, step_p, acc_pitch, longint'(weight_pitch));
      r.roll_angle = to_out16(round_half_up(roll_est, FracBits - 13));
      r.pitch_angle = to_out16(round_half_up(pitch_est, FracBits - 13));
      r.roll_rate = to_out16(round_half_up(cx * longint'(ictf_pkg::RateK), 20));
      r.pitch_rate = to_out16(round_half_up(cy * longint'(ictf_pkg::RateK), 20));
      expected_results.push_back(r);
   endtask

   task automatic check_field(string name, logic signed [15:0] exp_v, logic signed [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tilt_result_type e;
      if (reset) begin
         offset_x <= '0;
         offset_y <= '0;
         weight_roll <= ictf_pkg::WeightReset;
         weight_pitch <= ictf_pkg::WeightReset;
         roll_est = 0;
         pitch_est = 0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ictf_pkg::CSR_GYRO_OFFSET_X: offset_x <= csr_write_data;
               ictf_pkg::CSR_GYRO_OFFSET_Y: offset_y <= csr_write_data;
               ictf_pkg::CSR_ROLL_WEIGHT:   weight_roll <= csr_write_data;
               ictf_pkg::CSR_PITCH_WEIGHT:  weight_pitch <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_sample();
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("roll_angle", e.roll_angle, rsp_roll_angle);
               check_field("pitch_angle", e.pitch_angle, rsp_pitch_angle);
               check_field("roll_rate", e.roll_rate, rsp_roll_rate);
               check_field("pitch_rate", e.pitch_rate, rsp_pitch_rate);
            end
         end
      end
      pending_count <= expected_results.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

endmodule

>>> tb/tb_imu_complementary_tilt_filter.sv
// Testbench top for the complementary tilt filter: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_imu_complementary_tilt_filter;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [15:0] req_accel_x, req_accel_y, req_accel_z, req_gyro_x, req_gyro_y;
   logic [7:0] req_elapsed_ms;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_roll_rate, rsp_pitch_rate;
   logic csr_write_enable;
   logic [ictf_pkg::CsrIdxW-1:0] csr_index;
   logic [15:0] csr_write_data;
   int fail_count, pending_count;
   int samples_sent;

   imu_complementary_tilt_filter DUT (.*);
   imu_complementary_tilt_filter_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic signed [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(logic signed [15:0] ax, ay, az, gx, gy, logic [7:0] ms);
      req_valid <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_gyro_x <= gx;
      req_gyro_y <= gy;
      req_elapsed_ms <= ms;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      if ($urandom_range(0, 2) != 0) begin
         int gap;
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      if ($urandom_range(0, 9) < 6) begin
         // plausible sample: gravity mostly on z, small rotation
         send_sample(16'($signed($urandom_range(0, 8000)) - 4000),
                     16'($signed($urandom_range(0, 8000)) - 4000),
                     16'($signed($urandom_range(0, 8000)) + 12000),
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     8'($urandom_range(1, 20)));
      end else begin
         send_sample(pick16(), pick16(), pick16(), pick16(), pick16(), 8'($urandom));
      end
   endtask

   task automatic write_csr(logic [ictf_pkg::CsrIdxW-1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic set_registers(logic [15:0] ox, oy, wr, wp);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (60) @(posedge clock);
      write_csr(ictf_pkg::CSR_GYRO_OFFSET_X, ox);
      write_csr(ictf_pkg::CSR_GYRO_OFFSET_Y, oy);
      write_csr(ictf_pkg::CSR_ROLL_WEIGHT, wr);
      write_csr(ictf_pkg::CSR_PITCH_WEIGHT, wp);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (samples_sent >= 100 && samples_sent < 102) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_ready <= 1'b1;
            wait (samples_sent >= 102);
         end else if ($urandom_range(0, 29) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= ~rsp_ready;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      samples_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_gyro_x = '0;
      req_gyro_y = '0;
      req_elapsed_ms = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples at reset settings
      send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
      send_sample(16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 8'd10);
      send_sample(16'sd0, 16'sd0, -16'sd32768, 16'sd5, -16'sd5, 8'd1);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 8'd255);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 8'd255);
      send_sample(16'sd32767, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 8'd0);
      send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd1000, -16'sd1000, 8'd0);
      send_sample(16'sd0, 16'sd32767, 16'sd0, 16'sd131, -16'sd131, 8'd100);
      send_sample(16'sd0, -16'sd32768, 16'sd1, -16'sd1, 16'sd1, 8'd1);
      send_sample(16'sd100, -16'sd100, 16'sd16384, 16'h5555, 16'shAAAA, 8'h55);
      send_sample(16'h5555, 16'shAAAA, 16'h5555, 16'shAAAA, 16'h5555, 8'hAA);
      repeat (6) send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, 16'sd32767, 8'd255);
      repeat (6) send_sample(16'sd0, 16'sd0, 16'sd16384, -16'sd32768, -16'sd32768, 8'd255);

      set_registers(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      repeat (8) send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 8'd255);
      repeat (200) send_random();

      set_registers(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
      send_sample(16'sd1000, 16'sd2000, -16'sd3000, 16'sd0, 16'sd0, 8'd0);
      repeat (200) send_random();

      set_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      repeat (200) send_random();

      set_registers(16'($signed($urandom_range(0, 200)) - 100),
                    16'($signed($urandom_range(0, 200)) - 100), 16'h0001, 16'hFFFE);
      repeat (200) send_random();

      set_registers(16'h0000, 16'h0000, ictf_pkg::WeightReset, ictf_pkg::WeightReset);
      repeat (250) send_random();

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/ictf_pkg.sv
rtl/ictf_isqrt.sv
rtl/ictf_cordic_lane.sv
rtl/ictf_blend.sv
rtl/imu_complementary_tilt_filter.sv
rtl/ictf_checker.sv
tb/imu_complementary_tilt_filter_checker.sv
tb/tb_imu_complementary_tilt_filter.sv
